[sv/hmsc_pkg.sv]
`timescale 1ns / 1ps
// Package with the shared types, constants and step functions of the clock.
package hmsc_pkg;

  localparam int unsigned TpsWidth = 16;
  localparam int unsigned HourWidth = 5;
  localparam int unsigned MinWidth = 6;
  localparam int unsigned SecWidth = 6;

  localparam logic [TpsWidth-1:0] TpsReset = 16'd200;
  localparam logic [MinWidth-1:0] MinTop = 6'd59;
  localparam logic [SecWidth-1:0] SecTop = 6'd59;
  localparam logic [HourWidth-1:0] HourTop = 5'd23;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } hmsc_event_e;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_SET_MIN  = 2'd1,
    MODE_SET_HOUR = 2'd2
  } hmsc_mode_e;

  typedef struct packed {
    logic [HourWidth-1:0] hours;
    logic [MinWidth-1:0]  minutes;
    logic [SecWidth-1:0]  seconds;
    logic [TpsWidth-1:0]  prescale;
    hmsc_mode_e           mode;
  } hmsc_state_t;

  typedef struct packed {
    logic [HourWidth-1:0] hours;
    logic [MinWidth-1:0]  minutes;
    logic [SecWidth-1:0]  seconds;
    logic [1:0]           mode;
  } hmsc_result_t;

  // Step up with wrap to zero past the top value.
  function automatic logic [MinWidth-1:0] step_up(input logic [MinWidth-1:0] v,
                                                  input logic [MinWidth-1:0] top);
    step_up = (v >= top) ? '0 : v + 6'd1;
  endfunction

  // Step down with wrap to the top value; out-of-range values also go to the top.
  function automatic logic [MinWidth-1:0] step_down(input logic [MinWidth-1:0] v,
                                                    input logic [MinWidth-1:0] top);
    step_down = ((v == '0) || (v > top)) ? top : v - 6'd1;
  endfunction

endpackage

[sv/hmsc_if.sv]
`timescale 1ns / 1ps
// Interfaces for the button input channel, the time result channel and the configuration port.
interface hmsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] button1_event;
  logic [1:0] button2_event;
  modport source (output valid, output button1_event, output button2_event, input ready);
  modport sink (input valid, input button1_event, input button2_event, output ready);
endinterface

interface hmsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [hmsc_pkg::HourWidth-1:0] hours;
  logic [hmsc_pkg::MinWidth-1:0]  minutes;
  logic [hmsc_pkg::SecWidth-1:0]  seconds;
  logic [1:0]                    mode;
  modport source (output valid, output hours, output minutes, output seconds, output mode,
                  input ready);
  modport sink (input valid, input hours, input minutes, input seconds, input mode,
                output ready);
endinterface

interface hmsc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hmsc_pkg::TpsWidth-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/hmsc_update.sv]
`timescale 1ns / 1ps
// Next-state logic of the clock for one system tick.
module hmsc_update (
  input  hmsc_pkg::hmsc_state_t           state_i,
  input  logic [1:0]                      button1_event_i,
  input  logic [1:0]                      button2_event_i,
  input  logic [hmsc_pkg::TpsWidth-1:0]   ticks_per_second_i,
  output hmsc_pkg::hmsc_state_t           state_o
);

  logic                              long_any;
  logic                              double_any;
  logic [hmsc_pkg::TpsWidth-1:0]     pre_dec;
  logic [hmsc_pkg::MinWidth-1:0]     field;
  logic [hmsc_pkg::MinWidth-1:0]     top;
  logic                              hour_sel;

  assign long_any = (button1_event_i == hmsc_pkg::EV_LONG) ||
                    (button2_event_i == hmsc_pkg::EV_LONG);
  assign double_any = (button1_event_i == hmsc_pkg::EV_DOUBLE) ||
                      (button2_event_i == hmsc_pkg::EV_DOUBLE);
  assign pre_dec = (state_i.prescale != '0) ? state_i.prescale - 16'd1 : '0;
  assign hour_sel = (state_i.mode == hmsc_pkg::MODE_SET_HOUR);
  assign top = hour_sel ? {1'b0, hmsc_pkg::HourTop} : hmsc_pkg::MinTop;

  always_comb begin
    state_o = state_i;
    field = hour_sel ? {1'b0, state_i.hours} : state_i.minutes;
    case (state_i.mode)
      hmsc_pkg::MODE_NORMAL: begin
        state_o.prescale = pre_dec;
        if (long_any) begin
          state_o.mode = hmsc_pkg::MODE_SET_MIN;
        end else if (pre_dec == '0) begin
          state_o.prescale = ticks_per_second_i;
          if (state_i.seconds >= hmsc_pkg::SecTop) begin
            state_o.seconds = '0;
            if (state_i.minutes >= hmsc_pkg::MinTop) begin
              state_o.minutes = '0;
              state_o.hours = (state_i.hours >= hmsc_pkg::HourTop) ? '0
                                                                   : state_i.hours + 5'd1;
            end else begin
              state_o.minutes = state_i.minutes + 6'd1;
            end
          end else begin
            state_o.seconds = state_i.seconds + 6'd1;
          end
        end
      end
      hmsc_pkg::MODE_SET_MIN, hmsc_pkg::MODE_SET_HOUR: begin
        if (button1_event_i == hmsc_pkg::EV_SINGLE) begin
          field = hmsc_pkg::step_up(field, top);
        end
        if (button2_event_i == hmsc_pkg::EV_SINGLE) begin
          field = hmsc_pkg::step_down(field, top);
        end
        if (hour_sel) begin
          state_o.hours = field[hmsc_pkg::HourWidth-1:0];
        end else begin
          state_o.minutes = field;
        end
        if (long_any) begin
          state_o.mode = hmsc_pkg::MODE_NORMAL;
          state_o.seconds = '0;
        end
        if (double_any) begin
          state_o.mode = hour_sel ? hmsc_pkg::MODE_SET_MIN : hmsc_pkg::MODE_SET_HOUR;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

[sv/hms_clock_with_button_set_mode.sv]
`timescale 1ns / 1ps
// Top level of the 24-hour clock with button set mode.
// A tick's result is registered in the output register, or in the skid register while output waits.
// Throughput: one tick per cycle until both entries of the two-entry output buffer hold results.
// The state update is one pass of increment and compare logic between the state registers.
// Reset clears the time to 00:00:00 in normal mode and loads 200 into the prescaler and its reload.
module hms_clock_with_button_set_mode (
  input  logic            clk_i,
  input  logic            rst_ni,
  hmsc_in_if.sink         in_i,
  hmsc_out_if.source      res_o,
  hmsc_cfg_if.sink        cfg_i
);

  logic [hmsc_pkg::TpsWidth-1:0] tps_q;
  hmsc_pkg::hmsc_state_t         state_q;
  hmsc_pkg::hmsc_state_t         state_d;
  hmsc_pkg::hmsc_result_t        result;
  hmsc_pkg::hmsc_result_t        out_q;
  hmsc_pkg::hmsc_result_t        skid_q;
  logic                          out_valid_q;
  logic                          skid_valid_q;
  logic                          in_xfer;
  logic                          out_free;

  hmsc_update u_update (
    .state_i            (state_q),
    .button1_event_i    (in_i.button1_event),
    .button2_event_i    (in_i.button2_event),
    .ticks_per_second_i (tps_q),
    .state_o            (state_d)
  );

  assign in_i.ready = ~skid_valid_q;
  assign cfg_i.ready = 1'b1;
  assign in_xfer = in_i.valid & ~skid_valid_q;
  assign out_free = ~out_valid_q | res_o.ready;

  assign result.hours = state_d.hours;
  assign result.minutes = state_d.minutes;
  assign result.seconds = state_d.seconds;
  assign result.mode = state_d.mode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= hmsc_pkg::TpsReset;
    end else if (cfg_i.valid) begin
      tps_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.hours <= '0;
      state_q.minutes <= '0;
      state_q.seconds <= '0;
      state_q.prescale <= hmsc_pkg::TpsReset;
      state_q.mode <= hmsc_pkg::MODE_NORMAL;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= skid_valid_q | in_xfer;
      skid_valid_q <= 1'b0;
    end else if (in_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (in_xfer) begin
      skid_q <= result;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.hours = out_q.hours;
  assign res_o.minutes = out_q.minutes;
  assign res_o.seconds = out_q.seconds;
  assign res_o.mode = out_q.mode;

endmodule

[test/hmsc_time_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts the displayed time and mode for every tick transfer and compares results.
module hmsc_time_checker
  import hmsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  hmsc_in_if   tick_i,
  hmsc_out_if  time_i,
  hmsc_cfg_if  tps_i,
  output int   mismatches_o,
  output int   outstanding_o
);

  logic [HourWidth-1:0] hour_q;
  logic [MinWidth-1:0]  minute_q;
  logic [SecWidth-1:0]  second_q;
  logic [TpsWidth-1:0]  prescale_q;
  logic [TpsWidth-1:0]  reload_q;
  hmsc_mode_e           mode_q;
  hmsc_result_t         expected_times[$];
  int                   mismatch_count = 0;
  int                   pending = 0;

  assign mismatches_o  = mismatch_count;
  assign outstanding_o = pending;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("[%0t] time check: %s", $time, msg);
    end
  endtask

  function automatic int unsigned wrap_step(input int unsigned v, input int unsigned top,
                                            input bit up);
    if (up) begin
      return (v >= top) ? 0 : v + 1;
    end
    return ((v == 0) || (v > top)) ? top : v - 1;
  endfunction

  task automatic take_tick(input hmsc_event_e b1, input hmsc_event_e b2);
    bit long_any;
    bit double_any;
    bit hour_sel;
    long_any   = (b1 == EV_LONG) || (b2 == EV_LONG);
    double_any = (b1 == EV_DOUBLE) || (b2 == EV_DOUBLE);
    case (mode_q)
      MODE_NORMAL: begin
        if (prescale_q != '0) prescale_q = prescale_q - 1'b1;
        if (long_any) begin
          mode_q = MODE_SET_MIN;
        end else if (prescale_q == '0) begin
          prescale_q = reload_q;
          if (second_q >= SecTop) begin
            second_q = '0;
            if (minute_q >= MinTop) begin
              minute_q = '0;
              hour_q = (hour_q >= HourTop) ? '0 : hour_q + 1'b1;
            end else begin
              minute_q = minute_q + 1'b1;
            end
          end else begin
            second_q = second_q + 1'b1;
          end
        end
      end
      MODE_SET_MIN, MODE_SET_HOUR: begin
        hour_sel = (mode_q == MODE_SET_HOUR);
        if (b1 == EV_SINGLE) begin
          if (hour_sel) hour_q = HourWidth'(wrap_step(hour_q, HourTop, 1'b1));
          else minute_q = MinWidth'(wrap_step(minute_q, MinTop, 1'b1));
        end
        if (b2 == EV_SINGLE) begin
          if (hour_sel) hour_q = HourWidth'(wrap_step(hour_q, HourTop, 1'b0));
          else minute_q = MinWidth'(wrap_step(minute_q, MinTop, 1'b0));
        end
        if (long_any) begin
          mode_q   = MODE_NORMAL;
          second_q = '0;
        end
        if (double_any) mode_q = hour_sel ? MODE_SET_MIN : MODE_SET_HOUR;
      end
      default: ;
    endcase
    expected_times.push_back('{hours: hour_q, minutes: minute_q, seconds: second_q,
                               mode: mode_q});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hmsc_result_t want;
    if (!rst_ni) begin
      hour_q     = '0;
      minute_q   = '0;
      second_q   = '0;
      prescale_q = TpsReset;
      reload_q   = TpsReset;
      mode_q     = MODE_NORMAL;
      expected_times.delete();
      pending <= 0;
    end else begin
      if (tps_i.valid && tps_i.ready) reload_q = tps_i.data;
      if (time_i.valid && time_i.ready) begin
        if (expected_times.size() == 0) begin
          flag_mismatch($sformatf("result %0d:%0d:%0d mode %0d with no tick pending",
                                  time_i.hours, time_i.minutes, time_i.seconds, time_i.mode));
        end else begin
          want = expected_times.pop_front();
          if (time_i.hours !== want.hours) begin
            flag_mismatch($sformatf("hours got %0d, want %0d", time_i.hours, want.hours));
          end
          if (time_i.minutes !== want.minutes) begin
            flag_mismatch($sformatf("minutes got %0d, want %0d", time_i.minutes, want.minutes));
          end
          if (time_i.seconds !== want.seconds) begin
            flag_mismatch($sformatf("seconds got %0d, want %0d", time_i.seconds, want.seconds));
          end
          if (time_i.mode !== want.mode) begin
            flag_mismatch($sformatf("mode got %0d, want %0d", time_i.mode, want.mode));
          end
        end
      end
      if (tick_i.valid && tick_i.ready) begin
        take_tick(hmsc_event_e'(tick_i.button1_event), hmsc_event_e'(tick_i.button2_event));
      end
      pending <= expected_times.size();
    end
  end

endmodule

[test/hms_clock_with_button_set_mode_tb.sv]
`timescale 1ns / 1ps
// Testbench top that drives button ticks and prescaler settings into the clock and gives the verdict.
module hms_clock_with_button_set_mode_tb;
  import hmsc_pkg::*;

  typedef enum int {
    BURST_QUIET,
    BURST_EDIT,
    BURST_NOISE
  } burst_kind_e;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned PhaseTicks    = 192;
  localparam int unsigned HoldOffCycles = 300;

  logic        clk_i;
  logic        rst_ni;
  bit          no_gaps;
  bit          hold_off_on;
  int          mismatches;
  int          outstanding;
  int unsigned cycle_count = 0;

  hmsc_in_if  tick_if ();
  hmsc_out_if time_if ();
  hmsc_cfg_if tps_if ();

  hms_clock_with_button_set_mode uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .res_o  (time_if),
    .cfg_i  (tps_if)
  );

  hmsc_time_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick_if),
    .time_i        (time_if),
    .tps_i         (tps_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The one long hold-off lets the output buffer fill so the tick input stalls.
  initial begin
    int quiet;
    bit held;
    quiet = 0;
    held  = 1'b0;
    time_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (quiet > 0) begin
        quiet--;
        time_if.ready <= 1'b0;
      end else if (hold_off_on && !held) begin
        held  = 1'b1;
        quiet = HoldOffCycles;
        time_if.ready <= 1'b0;
      end else begin
        time_if.ready <= no_gaps || ($urandom_range(99) >= 22);
      end
    end
  end

  function automatic hmsc_event_e pick_event(input burst_kind_e kind);
    int unsigned r;
    r = $urandom_range(199);
    case (kind)
      BURST_QUIET: return (r == 0) ? hmsc_event_e'(2'($urandom_range(3))) : EV_NONE;
      BURST_EDIT: begin
        if (r < 60) return EV_NONE;
        if (r < 170) return EV_SINGLE;
        if (r < 194) return EV_DOUBLE;
        return EV_LONG;
      end
      default: return hmsc_event_e'(2'($urandom_range(3)));
    endcase
  endfunction

  task automatic send_tick(input hmsc_event_e b1, input hmsc_event_e b2);
    while (!no_gaps && ($urandom_range(99) < 22)) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid         <= 1'b1;
    tick_if.button1_event <= b1;
    tick_if.button2_event <= b2;
    do @(posedge clk_i); while (!tick_if.ready);
  endtask

  task automatic send_edit_burst(input int unsigned len);
    bit first_button;
    first_button = $urandom_range(1);
    send_tick(first_button ? EV_LONG : EV_NONE, first_button ? EV_NONE : EV_LONG);
    repeat (len) send_tick(pick_event(BURST_EDIT), pick_event(BURST_EDIT));
    send_tick(first_button ? EV_NONE : EV_LONG, first_button ? EV_LONG : EV_NONE);
  endtask

  task automatic settle();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_tps(input logic [TpsWidth-1:0] value);
    settle();
    tps_if.valid <= 1'b1;
    tps_if.data  <= value;
    do @(posedge clk_i); while (!tps_if.ready);
    tps_if.valid <= 1'b0;
  endtask

  initial begin
    logic [TpsWidth-1:0] tps_plan[8];
    int unsigned         sent;
    int unsigned         burst_len;
    int unsigned         r;
    burst_kind_e         kind;

    tps_plan = '{16'd1, 16'd0, 16'd2, 16'd1, 16'd4, 16'd0, 16'd3, 16'hFFFF};
    tps_plan[6] = TpsWidth'($urandom_range(9, 2));

    rst_ni                <= 1'b0;
    no_gaps               <= 1'b0;
    hold_off_on           <= 1'b0;
    tick_if.valid         <= 1'b0;
    tick_if.button1_event <= EV_NONE;
    tick_if.button2_event <= EV_NONE;
    tps_if.valid          <= 1'b0;
    tps_if.data           <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Normal mode ignores presses other than a long one; then set mode is entered, edited and left.
    send_tick(EV_NONE, EV_NONE);
    send_tick(EV_SINGLE, EV_DOUBLE);
    send_tick(EV_LONG, EV_NONE);
    send_tick(EV_SINGLE, EV_NONE);
    send_tick(EV_NONE, EV_SINGLE);
    send_tick(EV_NONE, EV_SINGLE);
    send_tick(EV_SINGLE, EV_NONE);
    send_tick(EV_SINGLE, EV_SINGLE);
    send_tick(EV_DOUBLE, EV_NONE);
    send_tick(EV_NONE, EV_SINGLE);
    send_tick(EV_SINGLE, EV_NONE);
    send_tick(EV_NONE, EV_SINGLE);
    send_tick(EV_NONE, EV_DOUBLE);
    send_tick(EV_NONE, EV_LONG);
    send_tick(EV_LONG, EV_LONG);
    send_tick(EV_LONG, EV_DOUBLE);
    send_tick(EV_DOUBLE, EV_LONG);
    send_tick(EV_DOUBLE, EV_DOUBLE);
    send_tick(EV_NONE, EV_LONG);
    send_tick(EV_NONE, EV_NONE);

    for (int p = 0; p < 8; p++) begin
      write_tps(tps_plan[p]);
      no_gaps <= (p == 3);
      if (p == 2) hold_off_on <= 1'b1;
      sent = 0;
      while (sent < PhaseTicks) begin
        r = $urandom_range(9);
        kind = (r < 5) ? BURST_QUIET : ((r < 9) ? BURST_EDIT : BURST_NOISE);
        if (kind == BURST_EDIT) begin
          burst_len = $urandom_range(25, 5);
          send_edit_burst(burst_len);
          sent += burst_len + 2;
        end else begin
          burst_len = (kind == BURST_QUIET) ? $urandom_range(120, 30) : $urandom_range(25, 5);
          repeat (burst_len) send_tick(pick_event(kind), pick_event(kind));
          sent += burst_len;
        end
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
